/* sv/idll_pkg.sv */
// package for the indexed doubly linked list core
// sizes, command and status codes, beat types, link reset values; no dependencies
`timescale 1ns / 1ps

package idll_pkg;

  localparam int unsigned CAPACITY    = 64;
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned SLOT_W      = $clog2(CAPACITY);
  // one extra bit so that the none code is no slot number
  localparam int unsigned LINK_W      = SLOT_W + 1;
  localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(CAPACITY);

  typedef enum logic [3:0] {
    CMD_INS_AFTER  = 4'd0,
    CMD_INS_BEFORE = 4'd1,
    CMD_INS_START  = 4'd2,
    CMD_INS_END    = 4'd3,
    CMD_DEL_INDEX  = 4'd4,
    CMD_DEL_START  = 4'd5,
    CMD_DEL_END    = 4'd6,
    CMD_FIND       = 4'd7,
    CMD_DEL_VALUE  = 4'd8
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_ABSENT = 2'd2,
    ST_BADIDX = 2'd3
  } status_e;

  typedef struct packed {
    logic [3:0]         command;
    logic [5:0]         index;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    status_e    status;
    logic [5:0] result_index;
  } out_item_t;

  // next link after reset: sentinel points to itself, free slots chain upward
  function automatic logic [LINK_W-1:0] next_reset(input logic [SLOT_W-1:0] a);
    logic [LINK_W-1:0] r;
    if (a == '0) begin
      r = '0;
    end else if (a == SLOT_W'(CAPACITY - 1)) begin
      r = LINK_NONE;
    end else begin
      r = LINK_W'(a) + LINK_W'(1);
    end
    return r;
  endfunction

  function automatic logic [LINK_W-1:0] prev_reset(input logic [SLOT_W-1:0] a);
    return (a == '0) ? '0 : LINK_NONE;
  endfunction

  function automatic logic link_ok(input logic [LINK_W-1:0] l);
    return l < LINK_W'(CAPACITY);
  endfunction

  function automatic logic [SLOT_W-1:0] slot_of(input logic [LINK_W-1:0] l);
    return l[SLOT_W-1:0];
  endfunction

endpackage

/* sv/idll_ram.sv */
// generic single write, single read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module idll_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/indexed_doubly_linked_list_core.sv */
// top level of the indexed doubly linked list core
// uses idll_pkg and three idll_ram instances (values, next links, prev links)
`timescale 1ns / 1ps

// A fixed-capacity doubly linked list kept in three rams with registered reads:
// values, next links and prev links. Slot 0 is the circular head sentinel and
// free slots chain through the next links. One command beat is taken at a time
// and gives one result beat (status and slot). A command walks a sequencer
// that issues at most one read per ram per cycle and writes back the changed links.
// A find or delete-by-value walks the list one element at a time and visits
// at most CAPACITY elements; rejected commands finish sooner. The sequencer
// returns to idle before it takes the next beat. The walk is paced by the
// dependent link reads through the ram read ports.
// The link rams need no clearing pass: a valid bit per entry makes an
// unwritten entry read as its reset link. A result waits in an output
// register; the next command is taken as soon as the sequencer is idle.
module indexed_doubly_linked_list_core
  import idll_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_RD0   = 15'b000000000000010,
    S_RD0_W = 15'b000000000000100,
    S_ANC   = 15'b000000000001000,
    S_ANC_W = 15'b000000000010000,
    S_OLD   = 15'b000000000100000,
    S_OLD_W = 15'b000000001000000,
    S_FRE_W = 15'b000000010000000,
    S_INS2  = 15'b000000100000000,
    S_DEL   = 15'b000001000000000,
    S_DEL_W = 15'b000010000000000,
    S_DEL2  = 15'b000100000000000,
    S_FND   = 15'b001000000000000,
    S_FND_W = 15'b010000000000000,
    S_DONE  = 15'b100000000000000
  } state_e;

  state_e state_q, state_d;

  // command context
  cmd_e                   cmd_q, cmd_d;
  logic [5:0]             idx_q, idx_d;
  logic [VALUE_WIDTH-1:0] val_q, val_d;
  logic [LINK_W-1:0]      anchor_q, anchor_d;   // insert goes after this slot
  logic [LINK_W-1:0]      old_q, old_d;         // anchor's old successor
  logic [LINK_W-1:0]      nfree_q, nfree_d;     // free head after insert
  logic [LINK_W-1:0]      tgt_q, tgt_d;         // slot to delete
  logic [LINK_W-1:0]      scan_q, scan_d;       // find walk position
  logic [SLOT_W-1:0]      cnt_q, cnt_d;         // find steps taken
  logic [LINK_W-1:0]      free_q, free_d;       // free list head
  status_e                st_q, st_d;
  logic [SLOT_W-1:0]      slot_q, slot_d;

  // result register
  logic      out_valid_q;
  out_item_t out_q;
  logic      out_load;

  // ram ports
  logic                   nx_we, pv_we, vs_we;
  logic [SLOT_W-1:0]      nx_wa, pv_wa, vs_wa;
  logic [LINK_W-1:0]      nx_wd, pv_wd;
  logic [VALUE_WIDTH-1:0] vs_wd;
  logic [SLOT_W-1:0]      nx_ra, pv_ra, vs_ra;
  logic [LINK_W-1:0]      nx_raw, pv_raw;
  logic [VALUE_WIDTH-1:0] vs_rd;

  // written flags for the link rams, sampled with each read
  logic [CAPACITY-1:0] nxv_q, pvv_q;
  logic                nx_rv_q, pv_rv_q;
  logic [SLOT_W-1:0]   nx_ra_q, pv_ra_q;
  logic [LINK_W-1:0]   nx_rd, pv_rd;

  idll_ram #(.WIDTH(LINK_W), .DEPTH(CAPACITY)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (nx_we),
    .waddr_i (nx_wa),
    .wdata_i (nx_wd),
    .raddr_i (nx_ra),
    .rdata_o (nx_raw)
  );

  idll_ram #(.WIDTH(LINK_W), .DEPTH(CAPACITY)) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (pv_we),
    .waddr_i (pv_wa),
    .wdata_i (pv_wd),
    .raddr_i (pv_ra),
    .rdata_o (pv_raw)
  );

  // value store: only slots in use are ever read, so no written flags
  idll_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(CAPACITY)) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (vs_we),
    .waddr_i (vs_wa),
    .wdata_i (vs_wd),
    .raddr_i (vs_ra),
    .rdata_o (vs_rd)
  );

  // an entry never written reads as its reset link
  assign nx_rd = nx_rv_q ? nx_raw : next_reset(nx_ra_q);
  assign pv_rd = pv_rv_q ? pv_raw : prev_reset(pv_ra_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nxv_q   <= '0;
      pvv_q   <= '0;
      nx_rv_q <= 1'b0;
      pv_rv_q <= 1'b0;
      nx_ra_q <= '0;
      pv_ra_q <= '0;
    end else begin
      if (nx_we) begin
        nxv_q[nx_wa] <= 1'b1;
      end
      if (pv_we) begin
        pvv_q[pv_wa] <= 1'b1;
      end
      // the sequencer never uses a read issued in the cycle it writes that entry
      nx_rv_q <= nxv_q[nx_ra];
      pv_rv_q <= pvv_q[pv_ra];
      nx_ra_q <= nx_ra;
      pv_ra_q <= pv_ra;
    end
  end

  // sequencer
  always_comb begin
    state_d  = state_q;
    cmd_d    = cmd_q;
    idx_d    = idx_q;
    val_d    = val_q;
    anchor_d = anchor_q;
    old_d    = old_q;
    nfree_d  = nfree_q;
    tgt_d    = tgt_q;
    scan_d   = scan_q;
    cnt_d    = cnt_q;
    free_d   = free_q;
    st_d     = st_q;
    slot_d   = slot_q;

    nx_we = 1'b0;
    nx_wa = '0;
    nx_wd = '0;
    pv_we = 1'b0;
    pv_wa = '0;
    pv_wd = '0;
    vs_we = 1'b0;
    vs_wa = '0;
    vs_wd = '0;
    nx_ra = '0;
    pv_ra = '0;
    vs_ra = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d  = cmd_e'(in_data_i.command);
          idx_d  = in_data_i.index;
          val_d  = in_data_i.value[VALUE_WIDTH-1:0];
          st_d   = ST_OK;
          slot_d = '0;
          case (cmd_e'(in_data_i.command))
            CMD_INS_AFTER: begin
              anchor_d = LINK_W'(in_data_i.index);
              state_d  = S_ANC;
            end
            CMD_INS_START: begin
              anchor_d = '0;
              state_d  = S_ANC;
            end
            CMD_INS_BEFORE, CMD_DEL_START, CMD_FIND, CMD_DEL_VALUE: begin
              state_d = S_RD0;
            end
            // these read prev of the sentinel
            CMD_INS_END, CMD_DEL_END: begin
              idx_d   = '0;
              state_d = S_RD0;
            end
            CMD_DEL_INDEX: begin
              tgt_d   = LINK_W'(in_data_i.index);
              state_d = S_DEL;
            end
            default: begin
              st_d    = ST_BADIDX;
              state_d = S_DONE;
            end
          endcase
        end
      end

      S_RD0: begin
        nx_ra   = '0;
        pv_ra   = SLOT_W'(idx_q);
        state_d = S_RD0_W;
      end

      S_RD0_W: begin
        case (cmd_q)
          CMD_INS_BEFORE, CMD_INS_END: begin
            if (idx_q != '0 && !link_ok(pv_rd)) begin
              st_d    = ST_BADIDX;
              state_d = S_DONE;
            end else begin
              anchor_d = pv_rd;
              state_d  = S_ANC;
            end
          end
          CMD_DEL_START: begin
            tgt_d   = nx_rd;
            state_d = S_DEL;
          end
          CMD_DEL_END: begin
            tgt_d   = pv_rd;
            state_d = S_DEL;
          end
          CMD_FIND, CMD_DEL_VALUE: begin
            scan_d  = nx_rd;
            cnt_d   = '0;
            state_d = S_FND;
          end
          default: begin
            st_d    = ST_BADIDX;
            state_d = S_DONE;
          end
        endcase
      end

      // anchor must be the sentinel or a slot in use
      S_ANC: begin
        if (!link_ok(anchor_q)) begin
          st_d    = ST_BADIDX;
          state_d = S_DONE;
        end else if (anchor_q == '0) begin
          state_d = S_OLD;
        end else begin
          pv_ra   = slot_of(anchor_q);
          state_d = S_ANC_W;
        end
      end

      S_ANC_W: begin
        if (!link_ok(pv_rd)) begin
          st_d    = ST_BADIDX;
          state_d = S_DONE;
        end else begin
          state_d = S_OLD;
        end
      end

      S_OLD: begin
        if (!link_ok(free_q)) begin
          st_d    = ST_FULL;
          state_d = S_DONE;
        end else begin
          nx_ra   = slot_of(anchor_q);
          state_d = S_OLD_W;
        end
      end

      S_OLD_W: begin
        old_d = nx_rd;
        if (!link_ok(nx_rd)) begin
          st_d    = ST_BADIDX;
          state_d = S_DONE;
        end else begin
          nx_ra   = slot_of(free_q);
          state_d = S_FRE_W;
        end
      end

      // link the fresh slot in after the anchor
      S_FRE_W: begin
        nfree_d = nx_rd;
        nx_we   = 1'b1;
        nx_wa   = slot_of(anchor_q);
        nx_wd   = free_q;
        pv_we   = 1'b1;
        pv_wa   = slot_of(free_q);
        pv_wd   = anchor_q;
        vs_we   = 1'b1;
        vs_wa   = slot_of(free_q);
        vs_wd   = val_q;
        state_d = S_INS2;
      end

      S_INS2: begin
        nx_we   = 1'b1;
        nx_wa   = slot_of(free_q);
        nx_wd   = old_q;
        pv_we   = 1'b1;
        pv_wa   = slot_of(old_q);
        pv_wd   = free_q;
        free_d  = nfree_q;
        st_d    = ST_OK;
        slot_d  = slot_of(free_q);
        state_d = S_DONE;
      end

      S_DEL: begin
        if (tgt_q == '0 || !link_ok(tgt_q)) begin
          st_d    = ST_BADIDX;
          state_d = S_DONE;
        end else begin
          nx_ra   = slot_of(tgt_q);
          pv_ra   = slot_of(tgt_q);
          state_d = S_DEL_W;
        end
      end

      // a free slot has prev none; unlink otherwise
      S_DEL_W: begin
        if (!link_ok(pv_rd) || !link_ok(nx_rd)) begin
          st_d    = ST_BADIDX;
          state_d = S_DONE;
        end else begin
          nx_we   = 1'b1;
          nx_wa   = slot_of(pv_rd);
          nx_wd   = nx_rd;
          pv_we   = 1'b1;
          pv_wa   = slot_of(nx_rd);
          pv_wd   = pv_rd;
          state_d = S_DEL2;
        end
      end

      // push the slot onto the free list
      S_DEL2: begin
        nx_we   = 1'b1;
        nx_wa   = slot_of(tgt_q);
        nx_wd   = free_q;
        pv_we   = 1'b1;
        pv_wa   = slot_of(tgt_q);
        pv_wd   = LINK_NONE;
        free_d  = tgt_q;
        st_d    = ST_OK;
        slot_d  = slot_of(tgt_q);
        state_d = S_DONE;
      end

      S_FND: begin
        if (scan_q == '0 || !link_ok(scan_q)) begin
          st_d    = ST_ABSENT;
          state_d = S_DONE;
        end else begin
          nx_ra   = slot_of(scan_q);
          vs_ra   = slot_of(scan_q);
          state_d = S_FND_W;
        end
      end

      S_FND_W: begin
        if (vs_rd == val_q) begin
          if (cmd_q == CMD_FIND) begin
            st_d    = ST_OK;
            slot_d  = slot_of(scan_q);
            state_d = S_DONE;
          end else begin
            tgt_d   = scan_q;
            state_d = S_DEL;
          end
        end else if (cnt_q == SLOT_W'(CAPACITY - 1)) begin
          st_d    = ST_ABSENT;
          state_d = S_DONE;
        end else begin
          scan_d  = nx_rd;
          cnt_d   = cnt_q + SLOT_W'(1);
          state_d = S_FND;
        end
      end

      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // result goes out once the output register is free
  assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      free_q      <= LINK_W'(1);
      out_valid_q <= 1'b0;
      cmd_q       <= CMD_INS_AFTER;
      st_q        <= ST_OK;
      cnt_q       <= '0;
    end else begin
      state_q <= state_d;
      free_q  <= free_d;
      cmd_q   <= cmd_d;
      st_q    <= st_d;
      cnt_q   <= cnt_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    val_q    <= val_d;
    anchor_q <= anchor_d;
    old_q    <= old_d;
    nfree_q  <= nfree_d;
    tgt_q    <= tgt_d;
    scan_q   <= scan_d;
    slot_q   <= slot_d;
    if (out_load) begin
      out_q.status       <= st_q;
      out_q.result_index <= (st_q == ST_OK) ? 6'(slot_q) : 6'd0;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* sim/indexed_doubly_linked_list_core_tb.sv */
// testbench for the indexed doubly linked list core
// drives command beats, predicts each result beat from its own list model; uses idll_pkg
`timescale 1ns / 1ps

module indexed_doubly_linked_list_core_tb;
  import idll_pkg::*;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_data_o;

  indexed_doubly_linked_list_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  localparam int unsigned NUM_RANDOM = 1300;
  localparam int unsigned NONE       = 9999;

  // list model state
  logic [31:0] slot_value[CAPACITY];
  int unsigned slot_next[CAPACITY];
  int unsigned slot_prev[CAPACITY];
  int unsigned free_slot;

  out_item_t pending_results[$];
  int        error_count;
  int        send_idle_pct;
  int        recv_idle_pct;
  int        hold_off_cycles;

  // directed table: command, index, value, whether the result is typed in, result
  typedef struct {
    cmd_e        cmd;
    logic [5:0]  idx;
    logic [31:0] val;
    bit          typed;
    status_e     st;
    logic [5:0]  slot;
  } dir_row_t;

  dir_row_t dir_rows[$];

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic bit slot_in_use(int unsigned s);
    return s != 0 && s < CAPACITY && slot_prev[s] != NONE;
  endfunction

  function automatic void reset_list();
    for (int unsigned i = 0; i < CAPACITY; i++) begin
      slot_value[i] = '0;
      slot_next[i]  = i + 1;
      slot_prev[i]  = NONE;
    end
    slot_next[CAPACITY-1] = NONE;
    slot_next[0] = 0;
    slot_prev[0] = 0;
    free_slot    = 1;
  endfunction

  function automatic status_e link_after(int unsigned anchor, logic [31:0] v,
                                         output int unsigned slot);
    int unsigned fresh, old;
    slot = 0;
    if (!(anchor == 0 || slot_in_use(anchor))) return ST_BADIDX;
    if (free_slot >= CAPACITY) return ST_FULL;
    fresh = free_slot;
    old   = slot_next[anchor];
    if (old >= CAPACITY) return ST_BADIDX;
    free_slot          = slot_next[fresh];
    slot_value[fresh]  = v;
    slot_next[anchor]  = fresh;
    slot_next[fresh]   = old;
    slot_prev[fresh]   = anchor;
    slot_prev[old]     = fresh;
    slot = fresh;
    return ST_OK;
  endfunction

  function automatic status_e unlink_slot(int unsigned s, output int unsigned slot);
    int unsigned n, p;
    slot = 0;
    if (!slot_in_use(s)) return ST_BADIDX;
    n = slot_next[s];
    p = slot_prev[s];
    if (n >= CAPACITY || p >= CAPACITY) return ST_BADIDX;
    slot_next[p]  = n;
    slot_prev[n]  = p;
    slot_value[s] = '0;
    slot_next[s]  = free_slot;
    slot_prev[s]  = NONE;
    free_slot     = s;
    slot = s;
    return ST_OK;
  endfunction

  function automatic int unsigned search_value(logic [31:0] v);
    int unsigned s;
    s = slot_next[0];
    for (int unsigned k = 0; k < CAPACITY; k++) begin
      if (s == 0 || s >= CAPACITY) return 0;
      if (slot_value[s] == v) return s;
      s = slot_next[s];
    end
    return 0;
  endfunction

  // apply one command to the list model and give the expected result beat
  function automatic out_item_t apply_command(in_item_t c);
    out_item_t   r;
    status_e     st;
    int unsigned slot, idx;
    logic [31:0] v;
    idx  = c.index;
    v    = c.value;
    slot = 0;
    case (c.command)
      CMD_INS_AFTER:  st = link_after(idx, v, slot);
      CMD_INS_BEFORE: begin
        if (idx == 0 || slot_in_use(idx)) st = link_after(slot_prev[idx], v, slot);
        else st = ST_BADIDX;
      end
      CMD_INS_START:  st = link_after(0, v, slot);
      CMD_INS_END:    st = link_after(slot_prev[0], v, slot);
      CMD_DEL_INDEX:  st = unlink_slot(idx, slot);
      CMD_DEL_START:  st = unlink_slot(slot_next[0], slot);
      CMD_DEL_END:    st = unlink_slot(slot_prev[0], slot);
      CMD_FIND: begin
        slot = search_value(v);
        st = (slot != 0) ? ST_OK : ST_ABSENT;
      end
      CMD_DEL_VALUE: begin
        slot = search_value(v);
        if (slot != 0) st = unlink_slot(slot, slot);
        else st = ST_ABSENT;
      end
      default: st = ST_BADIDX;
    endcase
    if (st != ST_OK) slot = 0;
    r.status       = st;
    r.result_index = slot[5:0];
    return r;
  endfunction

  // pick an index: mostly a live slot, sometimes anything
  function automatic logic [5:0] pick_index();
    int unsigned s;
    if ($urandom_range(0, 3) != 0) begin
      for (int k = 0; k < 8; k++) begin
        s = $urandom_range(0, CAPACITY - 1);
        if (slot_in_use(s)) return s[5:0];
      end
    end
    return 6'($urandom);
  endfunction

  // values from a small pool so finds hit, with full-range noise
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return $urandom;
      1:       return 32'h8000_0000;
      2:       return 32'h7fff_ffff;
      default: return 32'($urandom_range(0, 15));
    endcase
  endfunction

  function automatic in_item_t random_command(bit fill_phase, bit drain_phase);
    in_item_t c;
    int unsigned w;
    w = $urandom_range(0, 99);
    if (w < 2) c.command = 4'($urandom_range(9, 15));
    else if (fill_phase) c.command = 4'($urandom_range(0, 3));
    else if (drain_phase) c.command = 4'($urandom_range(4, 8));
    else c.command = 4'($urandom_range(0, 8));
    c.index = pick_index();
    c.value = pick_value();
    return c;
  endfunction

  task automatic send_beat(in_item_t c);
    in_valid_i <= 1'b1;
    in_data_i  <= c;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_results.push_back(apply_command(c));
  endtask

  task automatic sender_gap();
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      in_data_i  <= in_item_t'({$urandom, $urandom});
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic add_row(cmd_e cmd, logic [5:0] idx, logic [31:0] val, bit typed,
                         status_e st, logic [5:0] slot);
    dir_row_t r;
    r.cmd = cmd; r.idx = idx; r.val = val; r.typed = typed; r.st = st; r.slot = slot;
    dir_rows.push_back(r);
  endtask

  // result side: stall at random, check each beat against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result beat, actual %p", $time, out_data_o);
          error_count++;
        end else begin
          out_item_t exp_r;
          exp_r = pending_results.pop_front();
          if (out_data_o.status !== exp_r.status) begin
            $display("%0t: status mismatch, expected %0d actual %0d",
                     $time, exp_r.status, out_data_o.status);
            error_count++;
          end
          if (out_data_o.result_index !== exp_r.result_index) begin
            $display("%0t: result_index mismatch, expected %0d actual %0d",
                     $time, exp_r.result_index, out_data_o.result_index);
            error_count++;
          end
        end
      end
      // long hold-off counted here, so the core backs up into its input
      if (hold_off_cycles > 0) begin
        hold_off_cycles <= hold_off_cycles - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    in_item_t c;
    dir_row_t r;
    int       wait_cycles;
    error_count     = 0;
    send_idle_pct   = 26;
    recv_idle_pct   = 76;
    hold_off_cycles = 0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;
    reset_list();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty-list cases first, then edges; typed results only where obvious
    add_row(CMD_DEL_START,  6'd0,  32'd0,         1, ST_BADIDX, 6'd0);
    add_row(CMD_DEL_END,    6'd0,  32'd0,         1, ST_BADIDX, 6'd0);
    add_row(CMD_DEL_INDEX,  6'd0,  32'd0,         1, ST_BADIDX, 6'd0);
    add_row(CMD_DEL_INDEX,  6'd63, 32'd0,         1, ST_BADIDX, 6'd0);
    add_row(CMD_FIND,       6'd0,  32'd0,         1, ST_ABSENT, 6'd0);
    add_row(CMD_DEL_VALUE,  6'd0,  32'd0,         1, ST_ABSENT, 6'd0);
    add_row(CMD_INS_AFTER,  6'd5,  32'd1,         1, ST_BADIDX, 6'd0);
    add_row(CMD_INS_BEFORE, 6'd63, 32'd1,         1, ST_BADIDX, 6'd0);
    add_row(CMD_INS_START,  6'd0,  32'h8000_0000, 1, ST_OK,     6'd1);
    add_row(CMD_INS_END,    6'd0,  32'h7fff_ffff, 1, ST_OK,     6'd2);
    add_row(CMD_INS_BEFORE, 6'd0,  32'hffff_ffff, 1, ST_OK,     6'd3);
    add_row(CMD_INS_AFTER,  6'd0,  32'd0,         1, ST_OK,     6'd4);
    add_row(CMD_INS_AFTER,  6'd2,  32'd7,         0, ST_OK,     6'd0);
    add_row(CMD_INS_BEFORE, 6'd1,  32'd8,         0, ST_OK,     6'd0);
    add_row(CMD_FIND,       6'd0,  32'h7fff_ffff, 1, ST_OK,     6'd2);
    add_row(CMD_FIND,       6'd0,  32'h1234_5678, 1, ST_ABSENT, 6'd0);
    add_row(CMD_DEL_VALUE,  6'd0,  32'h8000_0000, 1, ST_OK,     6'd1);
    add_row(CMD_DEL_INDEX,  6'd1,  32'd0,         1, ST_BADIDX, 6'd0);
    add_row(CMD_DEL_START,  6'd0,  32'd0,         0, ST_OK,     6'd0);
    add_row(CMD_DEL_END,    6'd0,  32'd0,         0, ST_OK,     6'd0);
    add_row(CMD_DEL_INDEX,  6'd2,  32'd0,         0, ST_OK,     6'd0);
    add_row(cmd_e'(4'd9),   6'd0,  32'd0,         1, ST_BADIDX, 6'd0);
    add_row(cmd_e'(4'd15),  6'd63, 32'hffff_ffff, 1, ST_BADIDX, 6'd0);

    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      c.command = r.cmd;
      c.index   = r.idx;
      c.value   = r.val;
      send_beat(c);
      // typed-in results replace the predicted ones; the model still advances
      if (r.typed) begin
        pending_results[pending_results.size() - 1].status       = r.st;
        pending_results[pending_results.size() - 1].result_index = r.slot;
      end
      sender_gap();
    end

    // random part in three idling phases; each phase alternates fill and drain stretches
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin
        send_idle_pct = 76;
        recv_idle_pct = 26;
      end else if (ph == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off_cycles = 300;
      end
      for (int n = 0; n < NUM_RANDOM / 3; n++) begin
        c = random_command(n % 200 < 90, n % 200 >= 150);
        send_beat(c);
        sender_gap();
      end
    end
    in_valid_i <= 1'b0;

    wait_cycles = 0;
    while (pending_results.size() != 0 && wait_cycles < 100000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (2 * CAPACITY + 20) @(posedge clk_i);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
